// ===== src/fwpr_pkg.sv =====
// ----------------------------------------------------------------------------
// fwpr_pkg
// Types and constants shared by the prefix-reverse FIFO and its testbench.
// ----------------------------------------------------------------------------
package fwpr_pkg;

  // Ring size and the widths that follow from it.
  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Field widths of the transfer items.
  localparam int DATA_W = 32;
  localparam int KCNT_W = 7;
  localparam int CMP_W  = (CNT_W > KCNT_W) ? CNT_W : KCNT_W;

  // Operation codes.
  localparam logic [1:0] OP_ENQ = 2'd0;
  localparam logic [1:0] OP_DEQ = 2'd1;
  localparam logic [1:0] OP_REV = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // Front value reported for an empty queue.
  localparam logic signed [DATA_W-1:0] FRONT_EMPTY = '1;

  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [DATA_W-1:0] push_value;
    logic [KCNT_W-1:0]        reverse_count;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] front_value;
    logic                     queue_empty;
    logic [KCNT_W-1:0]        entry_count;
    logic [1:0]               op_status;
  } out_item_t;

endpackage

// ===== src/fifo_with_prefix_reverse.sv =====
// ----------------------------------------------------------------------------
// fifo_with_prefix_reverse
// FIFO of signed words in a ring memory with enqueue, dequeue and an in-place
// reversal of the first k entries.
// ----------------------------------------------------------------------------
// The block takes one operation at a time and returns one result for each.
// Enqueue, dequeue and ignored operations go from the input transfer through
// the front read and the capture state to the result. A reverse of k entries
// (k of two or more) swaps floor(k/2) pairs before the front read; each swap
// needs two reads and two writes through the single read port and single write
// port of the ring memory. in_stall is high from the input transfer until the
// result is loaded into the output register, and a result that is not taken
// holds the block until out_stall drops.
module fifo_with_prefix_reverse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fwpr_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output fwpr_pkg::out_item_t out_item
);

  import fwpr_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FRONT = 7'b0000010,
    S_CAPT  = 7'b0000100,
    S_RD_A  = 7'b0001000,
    S_RD_B  = 7'b0010000,
    S_WR_A  = 7'b0100000,
    S_WR_B  = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ADDR_W-1:0]   lo_r, lo_nxt;
  logic [ADDR_W-1:0]   hi_r, hi_nxt;
  logic [DATA_W-1:0]   tmp_r, tmp_nxt;
  logic [1:0]          status_r, status_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_item_r, out_item_nxt;

  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [DATA_W-1:0]   wr_data;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [DATA_W-1:0]   rd_data;

  logic                in_xfer;
  logic                out_free;
  logic [KCNT_W-1:0]   k_m1;
  logic                k_ok;

  // Ring position that lies off entries behind base.
  function automatic logic [ADDR_W-1:0] slot(input logic [ADDR_W-1:0] base,
                                             input logic [ADDR_W-1:0] off);
    logic [ADDR_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (ADDR_W + 1)'(DEPTH)) begin
      sum = sum - (ADDR_W + 1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  fwpr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign k_m1     = in_item.reverse_count - KCNT_W'(1);
  assign k_ok     = (in_item.reverse_count != '0) &&
                    (CMP_W'(in_item.reverse_count) <= CMP_W'(count_r));

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    tmp_nxt       = tmp_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt  = S_FRONT;
          status_nxt = ST_IGNORED;
          unique case (in_item.opcode)
            OP_ENQ: begin
              if (count_r >= CNT_W'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = slot(head_r, ADDR_W'(count_r));
                wr_data    = in_item.push_value;
                count_nxt  = count_r + CNT_W'(1);
                status_nxt = ST_DONE;
              end
            end
            OP_DEQ: begin
              if (count_r != '0) begin
                head_nxt   = slot(head_r, ADDR_W'(1));
                count_nxt  = count_r - CNT_W'(1);
                status_nxt = ST_DONE;
              end
            end
            OP_REV: begin
              if (k_ok) begin
                status_nxt = ST_DONE;
                lo_nxt     = '0;
                hi_nxt     = ADDR_W'(k_m1);
                // A single entry needs no swap.
                if (k_m1 != '0) begin
                  state_nxt = S_RD_A;
                end
              end
            end
            default: begin
              status_nxt = ST_IGNORED;
            end
          endcase
        end
      end
      S_RD_A: begin
        rd_en     = 1'b1;
        rd_addr   = slot(head_r, lo_r);
        state_nxt = S_RD_B;
      end
      S_RD_B: begin
        rd_en     = 1'b1;
        rd_addr   = slot(head_r, hi_r);
        tmp_nxt   = rd_data;
        state_nxt = S_WR_A;
      end
      S_WR_A: begin
        wr_en     = 1'b1;
        wr_addr   = slot(head_r, lo_r);
        wr_data   = rd_data;
        state_nxt = S_WR_B;
      end
      S_WR_B: begin
        wr_en   = 1'b1;
        wr_addr = slot(head_r, hi_r);
        wr_data = tmp_r;
        lo_nxt  = lo_r + ADDR_W'(1);
        hi_nxt  = hi_r - ADDR_W'(1);
        // The read of the next low entry overlaps this write.
        if (({1'b0, lo_r} + (ADDR_W + 1)'(2)) < {1'b0, hi_r}) begin
          rd_en     = 1'b1;
          rd_addr   = slot(head_r, lo_r + ADDR_W'(1));
          state_nxt = S_RD_B;
        end else begin
          state_nxt = S_FRONT;
        end
      end
      S_FRONT: begin
        rd_en     = 1'b1;
        rd_addr   = head_r;
        state_nxt = S_CAPT;
      end
      S_CAPT: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_item_nxt.front_value  = (count_r != '0) ? rd_data : FRONT_EMPTY;
          out_item_nxt.queue_empty  = (count_r == '0);
          out_item_nxt.entry_count  = KCNT_W'(count_r);
          out_item_nxt.op_status    = status_r;
          state_nxt                 = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    tmp_r      <= tmp_nxt;
    status_r   <= status_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // The fill level never passes the ring size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above ring depth");

  // The fill level and the head move only right after an input transfer.
  a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> $past(in_valid && !in_stall))
    else $error("entry count changed without an input transfer");

  a_head_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r != $past(head_r)) |-> $past(in_valid && !in_stall))
    else $error("head moved without an input transfer");

  // A swap pair always has its low offset below its high offset.
  a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD_B) |-> (lo_r < hi_r))
    else $error("swap offsets crossed");

endmodule

// ===== src/fwpr_ram.sv =====
// ----------------------------------------------------------------------------
// fwpr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fwpr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== test/fifo_with_prefix_reverse_tb.sv =====
// ----------------------------------------------------------------------------
// fifo_with_prefix_reverse_tb
// Self-checking bench for the prefix-reverse FIFO. A behavioral copy of the
// queue predicts the result of every accepted operation. Directed cases cover
// the empty queue and extreme words. Random traffic fills and drains the ring
// under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module fifo_with_prefix_reverse_tb;
  import fwpr_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 1_000_000;
  localparam int         SEGMENT_LEN = 70;
  localparam int         PHASE_ITEMS = 480;
  localparam int         REPORT_MAX  = 10;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // Behavioral copy of the queue contents.
  logic signed [DATA_W-1:0] mirror_ring [DEPTH];
  logic [ADDR_W-1:0]        mirror_head = '0;
  int                       mirror_count = 0;

  out_item_t pending_results [$];
  int        fail_count   = 0;
  int        cycle_count  = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;

  fifo_with_prefix_reverse dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [ADDR_W-1:0] slot_of(input int off);
    return ADDR_W'((int'(mirror_head) + off) % DEPTH);
  endfunction

  // Applies one operation to the mirror and returns the result it reports.
  function automatic out_item_t queue_after_op(input in_item_t op);
    out_item_t                res;
    logic [1:0]               status;
    int                       k;
    logic [ADDR_W-1:0]        a;
    logic [ADDR_W-1:0]        b;
    logic signed [DATA_W-1:0] tmp;
    status = ST_IGNORED;
    k = int'(op.reverse_count);
    case (op.opcode)
      OP_ENQ: begin
        if (mirror_count >= DEPTH) begin
          status = ST_FULL;
        end else begin
          mirror_ring[slot_of(mirror_count)] = op.push_value;
          mirror_count++;
          status = ST_DONE;
        end
      end
      OP_DEQ: begin
        if (mirror_count != 0) begin
          mirror_head = slot_of(1);
          mirror_count--;
          status = ST_DONE;
        end
      end
      OP_REV: begin
        if (k != 0 && k <= mirror_count) begin
          for (int i = 0; i < k / 2; i++) begin
            a = slot_of(i);
            b = slot_of(k - 1 - i);
            tmp = mirror_ring[a];
            mirror_ring[a] = mirror_ring[b];
            mirror_ring[b] = tmp;
          end
          status = ST_DONE;
        end
      end
      default: ;
    endcase
    res.front_value = (mirror_count != 0) ? mirror_ring[slot_of(0)] : FRONT_EMPTY;
    res.queue_empty = (mirror_count == 0);
    res.entry_count = KCNT_W'(mirror_count);
    res.op_status   = status;
    return res;
  endfunction

  // Random receiver stalls.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Result checker: every accepted result is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        if (fail_count < REPORT_MAX)
          $display("Unexpected result: front=%0d empty=%0b count=%0d status=%0d",
                   out_item.front_value, out_item.queue_empty, out_item.entry_count,
                   out_item.op_status);
        fail_count++;
      end else begin
        out_item_t want;
        want = pending_results.pop_front();
        if (out_item.front_value !== want.front_value ||
            out_item.queue_empty !== want.queue_empty ||
            out_item.entry_count !== want.entry_count ||
            out_item.op_status   !== want.op_status) begin
          if (fail_count < REPORT_MAX)
            $display("Mismatch: expected front=%0d empty=%0b count=%0d status=%0d, %s",
                     want.front_value, want.queue_empty, want.entry_count,
                     want.op_status,
                     $sformatf("got front=%0d empty=%0b count=%0d status=%0d",
                               out_item.front_value, out_item.queue_empty,
                               out_item.entry_count, out_item.op_status));
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Sends one operation and records its predicted result once the transfer happens.
  task automatic issue_op(input logic [1:0] opcode, input logic signed [DATA_W-1:0] word,
                          input logic [KCNT_W-1:0] k);
    in_item_t op;
    op.opcode        = opcode;
    op.push_value    = word;
    op.reverse_count = k;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= op;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(queue_after_op(op));
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] random_word();
    case ($urandom_range(31))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_queue();
    issue_op(OP_DEQ, $urandom, 7'd0);
    issue_op(OP_REV, $urandom, 7'd0);
    issue_op(OP_REV, $urandom, 7'd1);
    issue_op(OP_UNUSED, $urandom, 7'd127);
    wait_for_drain();
  endtask

  task automatic test_extremes_and_reverse();
    issue_op(OP_ENQ, 32'sh7FFF_FFFF, 7'd127);
    issue_op(OP_ENQ, 32'sh8000_0000, 7'd0);
    issue_op(OP_ENQ, '0, 7'd64);
    issue_op(OP_ENQ, '1, 7'd1);
    issue_op(OP_ENQ, 32'sh0000_0001, 7'd5);
    issue_op(OP_REV, $urandom, 7'd0);
    issue_op(OP_REV, $urandom, 7'd1);
    issue_op(OP_REV, $urandom, 7'd5);
    issue_op(OP_REV, $urandom, 7'd6);
    issue_op(OP_REV, $urandom, 7'd127);
    issue_op(OP_REV, $urandom, 7'd2);
    issue_op(OP_REV, $urandom, 7'd4);
    issue_op(OP_UNUSED, $urandom, 7'd3);
    repeat (6) issue_op(OP_DEQ, $urandom, KCNT_W'($urandom));
    wait_for_drain();
  endtask

  // Segments with a random enqueue weight push the ring between empty and full.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    int               enq_weight;
    int               pick;
    logic [1:0]       opcode;
    logic [KCNT_W-1:0] k;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (n % SEGMENT_LEN == 0) begin
        case ($urandom_range(4))
          0:       enq_weight = 15;
          1:       enq_weight = 45;
          2:       enq_weight = 80;
          3:       enq_weight = 95;
          default: enq_weight = 100;
        endcase
      end
      if ($urandom_range(99) < enq_weight)
        opcode = OP_ENQ;
      else if ($urandom_range(49) == 0)
        opcode = OP_UNUSED;
      else
        opcode = $urandom_range(1) ? OP_DEQ : OP_REV;
      pick = $urandom_range(99);
      if (opcode == OP_REV && mirror_count != 0 && pick < 60)
        k = KCNT_W'($urandom_range(mirror_count, 1));
      else if (opcode == OP_REV && mirror_count != 0 && pick < 75)
        k = KCNT_W'(mirror_count);
      else if (pick < 85)
        k = KCNT_W'($urandom_range(1));
      else
        k = KCNT_W'($urandom_range(127));
      issue_op(opcode, random_word(), k);
    end
    wait_for_drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_queue();
    test_extremes_and_reverse();
    test_random_traffic(0, 0);
    test_random_traffic(64, 0);
    test_random_traffic(0, 64);
    test_random_traffic(21, 21);
    repeat (120) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
